FILE: sv/lwrs_pkg.sv
// lwrs_pkg: shared widths, register indexes and the cell control bundle
// for the lagged window rank select core; no dependencies
package lwrs_pkg;

    localparam int SAMPLE_W     = 32;
    localparam int BARS_W       = 9;
    localparam int LAG_BARS_W   = 9;
    localparam int WINDOW_LEN_W = 7;
    localparam int RANK_W       = 7;
    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 2;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 48;
    localparam int M_TUSER_W    = 1;
    localparam int BARS_LSB     = SAMPLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_LAG_BARS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANK_WANTED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_HIGH   = 2'd3;

    typedef struct packed {
        logic clear;
        logic shift;
        logic high;
    } cell_ctrl_t;

endpackage

FILE: sv/lwrs_cell.sv
// lwrs_cell: one stage of the sorting chain, keeps the best entry seen
// and forwards the rest to its right neighbor; depends on lwrs_pkg
module lwrs_cell #(
    parameter int AGE_W = 6
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lwrs_pkg::cell_ctrl_t      ctrl,
    input  logic                      in_valid,
    input  logic signed [31:0]        in_value,
    input  logic [AGE_W-1:0]          in_age,
    input  logic                      nbr_valid,
    input  logic signed [31:0]        nbr_value,
    input  logic [AGE_W-1:0]          nbr_age,
    output logic                      held_valid,
    output logic signed [31:0]        held_value,
    output logic [AGE_W-1:0]          held_age,
    output logic                      pass_valid,
    output logic signed [31:0]        pass_value,
    output logic [AGE_W-1:0]          pass_age
);

    logic               held_valid_reg, held_valid_next;
    logic signed [31:0] held_value_reg, held_value_next;
    logic [AGE_W-1:0]   held_age_reg,   held_age_next;
    logic               pass_valid_reg, pass_valid_next;
    logic signed [31:0] pass_value_reg, pass_value_next;
    logic [AGE_W-1:0]   pass_age_reg,   pass_age_next;
    logic               in_first;

    // larger age is older
    function automatic logic ranks_before(
        input logic signed [31:0] va,
        input logic [AGE_W-1:0]   da,
        input logic signed [31:0] vb,
        input logic [AGE_W-1:0]   db,
        input logic               high
    );
        logic r;
        if (va != vb) begin
            r = high ? (va > vb) : (va < vb);
        end else begin
            r = high ? (da > db) : (da < db);
        end
        return r;
    endfunction

    assign in_first = !held_valid_reg ||
                      ranks_before(in_value, in_age, held_value_reg, held_age_reg, ctrl.high);

    always_comb begin
        held_valid_next = held_valid_reg;
        held_value_next = held_value_reg;
        held_age_next   = held_age_reg;
        pass_valid_next = 1'b0;
        pass_value_next = pass_value_reg;
        pass_age_next   = pass_age_reg;
        priority if (ctrl.clear) begin
            held_valid_next = 1'b0;
        end else if (ctrl.shift) begin
            held_valid_next = nbr_valid;
            held_value_next = nbr_value;
            held_age_next   = nbr_age;
        end else if (in_valid) begin
            if (in_first) begin
                held_valid_next = 1'b1;
                held_value_next = in_value;
                held_age_next   = in_age;
                pass_valid_next = held_valid_reg;
                pass_value_next = held_value_reg;
                pass_age_next   = held_age_reg;
            end else begin
                pass_valid_next = 1'b1;
                pass_value_next = in_value;
                pass_age_next   = in_age;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
        held_value_reg <= held_value_next;
        held_age_reg   <= held_age_next;
        pass_value_reg <= pass_value_next;
        pass_age_reg   <= pass_age_next;
    end

    assign held_valid = held_valid_reg;
    assign held_value = held_value_reg;
    assign held_age   = held_age_reg;
    assign pass_valid = pass_valid_reg;
    assign pass_value = pass_value_reg;
    assign pass_age   = pass_age_reg;

endmodule

FILE: sv/lagged_window_rank_select_core.sv
// lagged_window_rank_select_core: top level, history memory, sequencer and
// the row of sorting cells; depends on lwrs_pkg and lwrs_cell
//
//  channel | dir | ports                               | contents
//  --------+-----+-------------------------------------+-----------------------------
//  s_      | in  | s_tvalid s_tready s_tdata[31:0]     | sample
//  m_      | out | m_tvalid m_tready m_tdata m_tuser   | picked_value, bars_ago, flag
//  cfg_    | in  | cfg_wr_en cfg_index cfg_wdata[8:0]  | lag, window, rank, mode
//
// no-result item: take, then result register
// result item: LOAD reads the window entries into the chain, SETTLE lets it settle, SHIFT
//   moves the wanted rank to cell 0, DONE writes the result; size = window entries, rank clamped to size
// one item in work at a time; a result held by m_tready low does not stop the next take
// reset is synchronous, active low, and clears control state only; the history
// memory is never cleared, since only written entries are ranked
module lagged_window_rank_select_core #(
    parameter int MAX_LAG    = 256,
    parameter int MAX_WINDOW = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lwrs_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lwrs_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] picked_value,
                                                          // [40:32] bars_ago, rest zero
    output logic [lwrs_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] has_result
    input  logic                               cfg_wr_en,
    input  logic [lwrs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lwrs_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int HIST_SIZE = MAX_LAG + MAX_WINDOW;
    localparam int ADDR_W    = $clog2(HIST_SIZE);
    localparam int LAG_W     = $clog2(MAX_LAG + 1);
    localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int POS_W     = $clog2(2 * MAX_LAG + MAX_WINDOW + 1) + 1;
    localparam int CALC_W    = ((POS_W > lwrs_pkg::RANK_W) ? POS_W : lwrs_pkg::RANK_W) + 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_SETTLE = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    // configuration registers
    logic [lwrs_pkg::LAG_BARS_W-1:0]   lag_bars_reg;
    logic [lwrs_pkg::WINDOW_LEN_W-1:0] window_len_reg;
    logic [lwrs_pkg::RANK_W-1:0]       rank_wanted_reg;
    logic                              pick_high_reg;

    // history memory and read pipe
    logic signed [31:0] hist_mem [HIST_SIZE];
    logic signed [31:0] mem_q_reg;
    logic               rd_vld_reg;
    logic [AGE_W-1:0]   rd_age_reg;

    // sequencer and per-item state
    logic [2:0]        state_reg,  state_next;
    logic [ADDR_W-1:0] wptr_reg,   wptr_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AGE_W-1:0]  age_reg,    age_next;
    logic [WIN_W-1:0]  cnt_reg,    cnt_next;
    logic [WIN_W-1:0]  size_reg,   size_next;
    logic [AGE_W-1:0]  want_reg,   want_next;
    logic [LAG_W-1:0]  n_reg,      n_next;
    logic              active_reg, active_next;
    logic              high_reg,   high_next;

    // result register
    logic                              m_tvalid_reg, m_tvalid_next;
    logic [lwrs_pkg::M_TDATA_W-1:0]    m_tdata_reg,  m_tdata_next;
    logic [lwrs_pkg::M_TUSER_W-1:0]    m_tuser_reg,  m_tuser_next;

    // values worked out when an item is taken
    logic              in_acc;
    logic [LAG_W-1:0]  n_acc;
    logic [WIN_W-1:0]  m_acc;
    logic [CALC_W-1:0] pos_c, n_c, m_c, t_c, avail_c, size_c, pick_c, wptr_c, start_c;
    logic              active_acc;
    logic [CALC_W-1:0] back_c;

    // cell row
    lwrs_pkg::cell_ctrl_t cell_ctrl;
    logic               held_valid [MAX_WINDOW];
    logic signed [31:0] held_value [MAX_WINDOW];
    logic [AGE_W-1:0]   held_age   [MAX_WINDOW];
    logic               pass_valid [MAX_WINDOW];
    logic signed [31:0] pass_value [MAX_WINDOW];
    logic [AGE_W-1:0]   pass_age   [MAX_WINDOW];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lag_bars_reg    <= '0;
            window_len_reg  <= lwrs_pkg::WINDOW_LEN_W'(1);
            rank_wanted_reg <= lwrs_pkg::RANK_W'(1);
            pick_high_reg   <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lwrs_pkg::REG_LAG_BARS: begin
                    lag_bars_reg <= cfg_wdata[lwrs_pkg::LAG_BARS_W-1:0];
                end
                lwrs_pkg::REG_WINDOW_LEN: begin
                    window_len_reg <= cfg_wdata[lwrs_pkg::WINDOW_LEN_W-1:0];
                end
                lwrs_pkg::REG_RANK_WANTED: begin
                    rank_wanted_reg <= cfg_wdata[lwrs_pkg::RANK_W-1:0];
                end
                lwrs_pkg::REG_PICK_HIGH: begin
                    pick_high_reg <= cfg_wdata[0];
                end
            endcase
        end
    end

    // lag and window clamped to what the history holds
    assign n_acc = (32'(lag_bars_reg) > 32'(MAX_LAG)) ? LAG_W'(MAX_LAG) : LAG_W'(lag_bars_reg);
    assign m_acc = (32'(window_len_reg) > 32'(MAX_WINDOW)) ?
                   WIN_W'(MAX_WINDOW) : WIN_W'(window_len_reg);

    assign pos_c  = CALC_W'(pos_reg);
    assign n_c    = CALC_W'(n_acc);
    assign m_c    = CALC_W'(m_acc);
    assign t_c    = CALC_W'(rank_wanted_reg);
    assign wptr_c = CALC_W'(wptr_reg);

    // a result only for nonzero rank and window, once the position is past twice the lag
    assign active_acc = (t_c != '0) && (m_c != '0) && (pos_c > (n_c << 1));
    // window cut off at position 0
    assign avail_c = pos_c - n_c + CALC_W'(1);
    assign size_c  = (avail_c < m_c) ? avail_c : m_c;
    assign pick_c  = (t_c < size_c) ? t_c : size_c;
    // newest window entry lies n slots behind the slot being written
    assign start_c = (wptr_c >= n_c) ? (wptr_c - n_c) : (wptr_c + CALC_W'(HIST_SIZE) - n_c);

    // history memory, written on take, read every cycle
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            hist_mem[wptr_reg] <= $signed(s_tdata[31:0]);
        end
        mem_q_reg  <= hist_mem[rd_ptr_reg];
        rd_age_reg <= age_reg;
    end

    always_comb begin
        state_next    = state_reg;
        wptr_next     = wptr_reg;
        pos_next      = pos_reg;
        rd_ptr_next   = rd_ptr_reg;
        age_next      = age_reg;
        cnt_next      = cnt_reg;
        size_next     = size_reg;
        want_next     = want_reg;
        n_next        = n_reg;
        active_next   = active_reg;
        high_next     = high_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    wptr_next   = (wptr_reg == ADDR_W'(HIST_SIZE - 1)) ?
                                  '0 : wptr_reg + ADDR_W'(1);
                    pos_next    = (pos_reg == '1) ? pos_reg : pos_reg + POS_W'(1);
                    n_next      = n_acc;
                    size_next   = WIN_W'(size_c);
                    want_next   = AGE_W'(pick_c - CALC_W'(1));
                    active_next = active_acc;
                    high_next   = pick_high_reg;
                    rd_ptr_next = ADDR_W'(start_c);
                    age_next    = '0;
                    cnt_next    = WIN_W'(size_c);
                    state_next  = active_acc ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD: begin
                // one window entry per cycle, newest first
                rd_ptr_next = (rd_ptr_reg == '0) ?
                              ADDR_W'(HIST_SIZE - 1) : rd_ptr_reg - ADDR_W'(1);
                age_next    = age_reg + AGE_W'(1);
                cnt_next    = cnt_reg - WIN_W'(1);
                if (cnt_reg == WIN_W'(1)) begin
                    cnt_next   = size_reg;
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                // last entry may still travel down to cell size-1
                cnt_next = cnt_reg - WIN_W'(1);
                if (cnt_reg == WIN_W'(1)) begin
                    cnt_next   = WIN_W'(want_reg);
                    state_next = (want_reg == '0) ? ST_DONE : ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                cnt_next = cnt_reg - WIN_W'(1);
                if (cnt_reg == WIN_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = '0;
                    if (active_reg) begin
                        m_tdata_next[lwrs_pkg::SAMPLE_W-1:0] = held_value[0];
                        m_tdata_next[lwrs_pkg::BARS_LSB +: lwrs_pkg::BARS_W] =
                            lwrs_pkg::BARS_W'(back_c);
                        m_tuser_next[0] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // distance of the picked entry from the current position
    assign back_c = CALC_W'(n_reg) + CALC_W'(held_age[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wptr_reg     <= '0;
            pos_reg      <= '0;
            active_reg   <= 1'b0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            wptr_reg     <= wptr_next;
            pos_reg      <= pos_next;
            active_reg   <= active_next;
            rd_vld_reg   <= (state_reg == ST_LOAD);
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
        rd_ptr_reg  <= rd_ptr_next;
        age_reg     <= age_next;
        size_reg    <= size_next;
        want_reg    <= want_next;
        n_reg       <= n_next;
        high_reg    <= high_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // cell row: cleared on take, filled from the read pipe, shifted toward cell 0
    assign cell_ctrl.clear = in_acc;
    assign cell_ctrl.shift = (state_reg == ST_SHIFT);
    assign cell_ctrl.high  = high_reg;

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        logic               c_in_valid;
        logic signed [31:0] c_in_value;
        logic [AGE_W-1:0]   c_in_age;
        logic               c_nbr_valid;
        logic signed [31:0] c_nbr_value;
        logic [AGE_W-1:0]   c_nbr_age;

        if (k == 0) begin : g_head
            assign c_in_valid = rd_vld_reg;
            assign c_in_value = mem_q_reg;
            assign c_in_age   = rd_age_reg;
        end else begin : g_body
            assign c_in_valid = pass_valid[k-1];
            assign c_in_value = pass_value[k-1];
            assign c_in_age   = pass_age[k-1];
        end

        if (k == MAX_WINDOW - 1) begin : g_tail
            assign c_nbr_valid = 1'b0;
            assign c_nbr_value = '0;
            assign c_nbr_age   = '0;
        end else begin : g_mid
            assign c_nbr_valid = held_valid[k+1];
            assign c_nbr_value = held_value[k+1];
            assign c_nbr_age   = held_age[k+1];
        end

        lwrs_cell #(
            .AGE_W (AGE_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .in_valid   (c_in_valid),
            .in_value   (c_in_value),
            .in_age     (c_in_age),
            .nbr_valid  (c_nbr_valid),
            .nbr_value  (c_nbr_value),
            .nbr_age    (c_nbr_age),
            .held_valid (held_valid[k]),
            .held_value (held_value[k]),
            .held_age   (held_age[k]),
            .pass_valid (pass_valid[k]),
            .pass_value (pass_value[k]),
            .pass_age   (pass_age[k])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: sv/lwrs_checker.sv
// lwrs_checker: port-level checks of the rank select core, bound to the
// top level; depends on lwrs_pkg and lagged_window_rank_select_core
module lwrs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [lwrs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [lwrs_pkg::M_TUSER_W-1:0]  m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // zero-filled item carries all-zero data
    a_zero_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == '0) |-> (m_tdata == '0))
        else $error("zero-filled item with nonzero data");

    // one item in work at a time
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while another is in work");

    // a result only appears at the end of an item's work
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared with no item in work");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind lagged_window_rank_select_core lwrs_checker u_lwrs_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

FILE: sim/tb_lagged_window_rank_select_core.sv
// tb_lagged_window_rank_select_core: self-checking testbench for the lagged window rank
// select core, with a window rank tracker class that predicts each picked sample
// depends on lwrs_pkg and lagged_window_rank_select_core
`timescale 1ns / 1ps

typedef struct packed {
    logic [lwrs_pkg::BARS_W-1:0]          bars;
    logic signed [lwrs_pkg::SAMPLE_W-1:0] value;
    logic                                 found;
} pick_t;

class window_rank_tracker;
    localparam int LAG_CAP    = 256;
    localparam int WINDOW_CAP = 64;
    localparam int DEPTH      = LAG_CAP + WINDOW_CAP;

    logic signed [lwrs_pkg::SAMPLE_W-1:0]   history [DEPTH];
    int unsigned                            write_slot;
    bit [31:0]                              position;
    bit [lwrs_pkg::LAG_BARS_W-1:0]          lag;
    bit [lwrs_pkg::WINDOW_LEN_W-1:0]        win;
    bit [lwrs_pkg::RANK_W-1:0]              rank;
    bit                                     high;
    pick_t                                  pending_picks [$];
    int unsigned                            mismatches;

    function new();
        foreach (history[k]) history[k] = '0;
        write_slot = 0;
        position   = 0;
        lag        = 0;
        win        = 1;
        rank       = 1;
        high       = 1'b1;
        mismatches = 0;
    endfunction

    function void set_register(logic [lwrs_pkg::CFG_IDX_W-1:0] idx,
                               logic [lwrs_pkg::CFG_W-1:0] val);
        case (idx)
            lwrs_pkg::REG_LAG_BARS:    lag  = val[lwrs_pkg::LAG_BARS_W-1:0];
            lwrs_pkg::REG_WINDOW_LEN:  win  = val[lwrs_pkg::WINDOW_LEN_W-1:0];
            lwrs_pkg::REG_RANK_WANTED: rank = val[lwrs_pkg::RANK_W-1:0];
            lwrs_pkg::REG_PICK_HIGH:   high = val[0];
            default: ;
        endcase
    endfunction

    function int pending();
        return pending_picks.size();
    endfunction

    // sample lying back bars before the newest one
    function logic signed [lwrs_pkg::SAMPLE_W-1:0] look_back(int unsigned back);
        return history[(write_slot + DEPTH - 1 - back) % DEPTH];
    endfunction

    // offsets grow toward older samples
    function bit outranks(logic signed [lwrs_pkg::SAMPLE_W-1:0] va, int unsigned da,
                          logic signed [lwrs_pkg::SAMPLE_W-1:0] vb, int unsigned db);
        if (va != vb) return high ? (va > vb) : (va < vb);
        return high ? (da > db) : (da < db);
    endfunction

    function void take_sample(logic [lwrs_pkg::SAMPLE_W-1:0] sample);
        longint unsigned pos;
        int unsigned     n, m, t, s, size, want, ahead;
        pick_t           pick;
        pos = position;
        n = (lag > LAG_CAP) ? LAG_CAP : lag;
        m = (win > WINDOW_CAP) ? WINDOW_CAP : win;
        t = rank;
        history[write_slot] = sample;
        write_slot = (write_slot + 1) % DEPTH;
        if (position != 32'hFFFF_FFFF) position++;
        pick = '0;
        if (t != 0 && m != 0 && pos > 2 * longint'(n)) begin
            s = 32'(pos - n);
            size = m;
            // window cut off at the first sample after reset
            if (longint'(s) + 1 < size) size = s + 1;
            want = ((t < size) ? t : size) - 1;
            for (int a = 0; a < size; a++) begin
                ahead = 0;
                for (int b = 0; b < size; b++) begin
                    if (b != a && outranks(look_back(n + b), b, look_back(n + a), a))
                        ahead++;
                end
                if (ahead == want) begin
                    pick.value = look_back(n + a);
                    pick.bars  = lwrs_pkg::BARS_W'(n + a);
                    pick.found = 1'b1;
                    break;
                end
            end
        end
        pending_picks.insert(pending_picks.size(), pick);
    endfunction

    function void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function void compare_pick(logic [lwrs_pkg::M_TDATA_W-1:0] tdata,
                               logic [lwrs_pkg::M_TUSER_W-1:0] tuser);
        pick_t                                want;
        logic signed [lwrs_pkg::SAMPLE_W-1:0] got_value;
        logic [lwrs_pkg::BARS_W-1:0]          got_bars;
        logic [lwrs_pkg::M_TDATA_W-1:0]       pad;
        if (pending_picks.size() == 0) begin
            flag_mismatch($sformatf("result with no item waiting: tdata %h tuser %b",
                                    tdata, tuser));
            return;
        end
        want      = pending_picks.pop_front();
        got_value = tdata[lwrs_pkg::SAMPLE_W-1:0];
        got_bars  = tdata[lwrs_pkg::BARS_LSB +: lwrs_pkg::BARS_W];
        pad       = tdata >> (lwrs_pkg::BARS_LSB + lwrs_pkg::BARS_W);
        if (got_value !== want.value || got_bars !== want.bars
                || tuser[0] !== want.found || pad !== '0)
            flag_mismatch($sformatf(
                "value exp %0d got %0d, bars exp %0d got %0d, flag exp %b got %b, pad %h",
                want.value, got_value, want.bars, got_bars, want.found, tuser[0], pad));
    endfunction
endclass

module tb_lagged_window_rank_select_core;

    localparam int LIMIT_CYCLES    = 3_000_000;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 90;
    // longest item: full-window fill and settle, rank shifts, plus overhead
    localparam int SETTLE_CYCLES   = 300;

    // directed sample runs
    localparam logic [lwrs_pkg::SAMPLE_W-1:0] TIE_RUN [7] = '{
        32'd5, 32'hFFFF_FFFF, 32'd5, 32'h8000_0000, 32'd5, 32'h7FFF_FFFF, 32'hFFFF_FFFF
    };
    localparam logic [lwrs_pkg::SAMPLE_W-1:0] LOW_RUN [4] = '{
        32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000
    };

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic [lwrs_pkg::S_TDATA_W-1:0]     s_tdata   = '0;
    logic                               m_tready  = 1'b0;
    logic                               cfg_wr_en = 1'b0;
    logic [lwrs_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [lwrs_pkg::CFG_W-1:0]         cfg_wdata = '0;
    wire                                s_tready;
    wire                                m_tvalid;
    wire [lwrs_pkg::M_TDATA_W-1:0]      m_tdata;
    wire [lwrs_pkg::M_TUSER_W-1:0]      m_tuser;

    // idle chance per cycle, in percent, for each side
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count   = 0;

    window_rank_tracker tracker = new();

    lagged_window_rank_select_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [31:0] sample
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [31:0] picked_value, [40:32] bars_ago, rest zero
        .m_tuser   (m_tuser),    // [0] has_result
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // both channels are sampled at the rising edge, before the block updates
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) tracker.take_sample(s_tdata);
            if (m_tvalid && m_tready) tracker.compare_pick(m_tdata, m_tuser);
        end
    end

    // receiver stalls at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one register write, enable left high for the next one
    task automatic put_register(input logic [lwrs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lwrs_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        tracker.set_register(idx, val);
        @(negedge aclk);
    endtask

    // all four registers, written back to back while the block is idle
    task automatic write_registers(input logic [lwrs_pkg::CFG_W-1:0] lag,
                                   input logic [lwrs_pkg::CFG_W-1:0] win,
                                   input logic [lwrs_pkg::CFG_W-1:0] rank,
                                   input logic [lwrs_pkg::CFG_W-1:0] high);
        put_register(lwrs_pkg::REG_LAG_BARS, lag);
        put_register(lwrs_pkg::REG_WINDOW_LEN, win);
        put_register(lwrs_pkg::REG_RANK_WANTED, rank);
        put_register(lwrs_pkg::REG_PICK_HIGH, high);
        cfg_wr_en <= 1'b0;
    endtask

    // offer one item, with random idle cycles ahead of it; returns at a falling edge
    task automatic send_sample(input logic [lwrs_pkg::SAMPLE_W-1:0] sample);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // stop offering and wait for every predicted pick to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
    endtask

    // mostly full-range values, plus tiny values that tie often and the extremes
    function automatic logic [lwrs_pkg::SAMPLE_W-1:0] random_sample();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return $urandom;
        if (roll < 85) return int'($urandom_range(6)) - 3;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic random_phase(input int ph);
        logic [lwrs_pkg::CFG_W-1:0] lag, win, rank, high;
        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 55; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 55; end
            default: begin send_idle_pct = 14; recv_idle_pct = 14; end
        endcase
        // a few phases pinned to the register extremes, the rest small and random
        case (ph)
            3:  begin lag = 0;   win = 127; rank = 127; high = 0; end
            6:  begin lag = 1;   win = 64;  rank = 1;   high = 1; end
            9:  begin lag = 256; win = 64;  rank = 64;  high = 1; end
            12: begin lag = 511; win = 8;   rank = 3;   high = 0; end
            14: begin lag = 20;  win = 0;   rank = 5;   high = 1; end
            default: begin
                lag  = lwrs_pkg::CFG_W'(($urandom_range(99) < 70) ?
                                        $urandom_range(6) : $urandom_range(60));
                win  = lwrs_pkg::CFG_W'($urandom_range(12, 1));
                rank = lwrs_pkg::CFG_W'($urandom_range(32'(win) + 2));
                high = lwrs_pkg::CFG_W'($urandom_range(1));
            end
        endcase
        write_registers(lag, win, rank, high);
        for (int k = 0; k < ITEMS_PER_PHASE; k++) send_sample(random_sample());
        drain_results();
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: lag 0, window 1, rank 1, high; first item has no result
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        drain_results();

        // early items give no result, then the window grows from the first sample
        write_registers(9'd2, 9'd8, 9'd2, 9'd1);
        foreach (TIE_RUN[k]) send_sample(TIE_RUN[k]);
        drain_results();

        // oversized window and rank in low mode
        write_registers(9'd0, 9'd127, 9'd127, 9'd0);
        foreach (LOW_RUN[k]) send_sample(LOW_RUN[k]);
        drain_results();

        // rank zero
        write_registers(9'd3, 9'd5, 9'd0, 9'd1);
        send_sample(32'd7);
        send_sample(32'hFFFF_FFF0);
        drain_results();

        // empty window
        write_registers(9'd0, 9'd0, 9'd3, 9'd0);
        send_sample(32'd9);
        send_sample(32'd9);
        drain_results();

        // oversized lag, still within twice the lag
        write_registers(9'd511, 9'd64, 9'd64, 9'd1);
        send_sample(32'd1);
        send_sample(32'h8000_0001);
        drain_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) random_phase(ph);

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
